[design/assert_macros.svh]
// assertion macros used by the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert a property on rising clk, disabled in reset
`define CHK_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// assert a property on rising clk, also during reset
`define CHK_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);
`endif

[design/lpof_pkg.sv]
// types and constants for the lidar projection occlusion filter
// no dependencies
`default_nettype none
package lpof_pkg;
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               scan_start;
  } in_word_t;

  typedef struct packed {
    logic               kept;
    logic        [11:0] slot;
    logic        [12:0] popped;
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic               overflow;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic signed [31:0] bottom;
  } cfg_regs_t;

  localparam logic [2:0] REG_SHIFT_X = 3'd0;
  localparam logic [2:0] REG_SHIFT_Y = 3'd1;
  localparam logic [2:0] REG_SHIFT_Z = 3'd2;
  localparam logic [2:0] REG_LEFT    = 3'd3;
  localparam logic [2:0] REG_RIGHT   = 3'd4;
  localparam logic [2:0] REG_TOP     = 3'd5;
  localparam logic [2:0] REG_BOTTOM  = 3'd6;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) sat_add = 32'sh7fffffff;
    else if (s < -33'sd2147483648) sat_add = 32'sh80000000;
    else sat_add = s[31:0];
  endfunction
endpackage
`default_nettype wire

[design/lpof_cfg.sv]
// apb register file for the filter's translation and window registers
// depends on lpof_pkg
`default_nettype none
module lpof_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output lpof_pkg::cfg_regs_t    regs
);
  lpof_pkg::cfg_regs_t regs_r;
  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;
  assign regs = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        lpof_pkg::REG_SHIFT_X: regs_r.shift_x <= pwdata;
        lpof_pkg::REG_SHIFT_Y: regs_r.shift_y <= pwdata;
        lpof_pkg::REG_SHIFT_Z: regs_r.shift_z <= pwdata;
        lpof_pkg::REG_LEFT:    regs_r.left    <= pwdata;
        lpof_pkg::REG_RIGHT:   regs_r.right   <= pwdata;
        lpof_pkg::REG_TOP:     regs_r.top     <= pwdata;
        lpof_pkg::REG_BOTTOM:  regs_r.bottom  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lpof_pkg::REG_SHIFT_X: prdata = regs_r.shift_x;
      lpof_pkg::REG_SHIFT_Y: prdata = regs_r.shift_y;
      lpof_pkg::REG_SHIFT_Z: prdata = regs_r.shift_z;
      lpof_pkg::REG_LEFT:    prdata = regs_r.left;
      lpof_pkg::REG_RIGHT:   prdata = regs_r.right;
      lpof_pkg::REG_TOP:     prdata = regs_r.top;
      lpof_pkg::REG_BOTTOM:  prdata = regs_r.bottom;
      default:               prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

[design/lpof_div.sv]
// shared restoring divider, one quotient bit per cycle, signed result saturated
// no dependencies
`default_nettype none
module lpof_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  // |num|<<16 <= 2^47, quotient fits 48 bits
  logic [47:0] q_r, q_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [47:0] dvd_r, dvd_nxt;
  logic [31:0] dv_r;
  logic        neg_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r;
  logic [48:0] trial;
  logic [47:0] mag;

  always_comb begin
    trial = {rem_r, dvd_r[47]} - {17'd0, dv_r};
    rem_nxt = {rem_r[46:0], dvd_r[47]};
    q_nxt = {q_r[46:0], 1'b0};
    if (!trial[48]) begin
      rem_nxt = trial[47:0];
      q_nxt[0] = 1'b1;
    end
    dvd_nxt = {dvd_r[46:0], 1'b0};
    cnt_nxt = cnt_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd48;
      end else if (busy_r) begin
        cnt_r <= cnt_nxt;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
      dv_r <= den;
      neg_r <= num[31];
      rem_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      q_r <= q_nxt;
    end
  end

  assign mag = q_r;
  always_comb begin
    if (neg_r) quo = (mag > 48'h80000000) ? 32'sh80000000 : 32'(-mag);
    else quo = (mag > 48'h7fffffff) ? 32'sh7fffffff : mag[31:0];
  end
endmodule
`default_nettype wire

[design/lidar_projection_occlusion_filter.sv]
// top level: translation, shared divider, window test and occlusion stack
// depends on lpof_pkg, lpof_cfg, lpof_div
// usage:
// in_ channel takes one point word (x, y, z, scan_start) with valid/ready.
// out_ channel returns one result word per point with valid/ready.
// cfg_ is an apb port with seven 32-bit registers at byte address 4*i.
// a point with positive depth uses the shared divider twice;
// a point inside the window then reads the stack top and compares,
// and repeats both for each popped entry (registered memory read).
// out_valid rises after the stack step, after the second divide outside the
// window, and with no divide or stack step for non-positive depth; in_ready is
// low meanwhile, so the filter holds off a new word until the result is out.
// pops amortize to one per push.
// reset clears the state and the stack count; datapath registers and stack contents are undefined.
// the result register holds while out_ready is low, and a new point is
// taken only after the previous result is delivered.
`default_nettype none
module lidar_projection_occlusion_filter #(
  parameter int STACK_DEPTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lpof_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lpof_pkg::out_word_t       out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [4:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVX = 3'd1;
  localparam logic [2:0] S_DIVY = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  lpof_pkg::cfg_regs_t regs;
  lpof_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .regs
  );

  logic [2:0] state_r;
  logic signed [31:0] py_r, pz_r, cx_r;
  logic [CW-1:0] cnt_r;
  logic [12:0] pop_r;
  lpof_pkg::out_word_t res_r;

  logic div_start, div_done;
  logic signed [31:0] div_num, div_den, div_quo;
  lpof_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  logic signed [31:0] mem_x [STACK_DEPTH];
  logic signed [31:0] mem_z [STACK_DEPTH];
  logic signed [31:0] top_x_r, top_z_r;
  logic we;
  logic [AW-1:0] rd_addr;

  assign rd_addr = AW'(cnt_r - CW'(1));
  assign we = (state_r == S_CMP) &&
              !((cnt_r != '0) && (cx_r < top_x_r) && (pz_r != top_z_r)) &&
              (cnt_r != FULL);

  always_ff @(posedge clk) begin
    top_x_r <= mem_x[rd_addr];
    top_z_r <= mem_z[rd_addr];
    if (we) begin
      mem_x[cnt_r[AW-1:0]] <= cx_r;
      mem_z[cnt_r[AW-1:0]] <= pz_r;
    end
  end

  logic signed [31:0] xsum, zsum;
  assign xsum = lpof_pkg::sat_add(in_data.point_x, regs.shift_x);
  assign zsum = lpof_pkg::sat_add(in_data.point_z, regs.shift_z);

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = res_r;
  assign div_num = (state_r == S_IDLE) ? xsum : py_r;
  assign div_den = (state_r == S_IDLE) ? zsum : pz_r;

  logic in_win;
  assign in_win = (cx_r >= regs.left) && (cx_r < regs.right) &&
                  (div_quo >= regs.top) && (div_quo < regs.bottom);

  always_comb begin
    div_start = 1'b0;
    if (state_r == S_IDLE && in_valid && zsum > 0) div_start = 1'b1;
    if (state_r == S_DIVX && div_done) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          py_r <= lpof_pkg::sat_add(in_data.point_y, regs.shift_y);
          pz_r <= zsum;
          if (in_data.scan_start) cnt_r <= '0;
          pop_r <= '0;
          res_r <= '0;
          if (zsum > 0) state_r <= S_DIVX;
          else state_r <= S_OUT;
        end
        S_DIVX: if (div_done) begin
          cx_r <= div_quo;
          res_r.proj_x <= div_quo;
          state_r <= S_DIVY;
        end
        S_DIVY: if (div_done) begin
          res_r.proj_y <= div_quo;
          state_r <= in_win ? S_RD : S_OUT;
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (cnt_r != '0 && cx_r < top_x_r && pz_r < top_z_r) begin
            cnt_r <= cnt_r - CW'(1);
            pop_r <= pop_r + 13'd1;
            state_r <= S_RD;
          end else begin
            res_r.popped <= pop_r;
            if (cnt_r != '0 && cx_r < top_x_r && pz_r > top_z_r) begin
              state_r <= S_OUT;
            end else if (cnt_r == FULL) begin
              res_r.overflow <= 1'b1;
              state_r <= S_OUT;
            end else begin
              res_r.kept <= 1'b1;
              res_r.slot <= 12'(cnt_r);
              cnt_r <= cnt_r + CW'(1);
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/lpof_checker.sv]
// port-level checker for the filter, bound to the top level
// depends on lpof_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module lpof_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire lpof_pkg::out_word_t out_data,
  input wire logic                cfg_pready
);
  `CHK_ASSERT(a_excl, clk, rst_n, !(in_ready && out_valid), "ready while result pending")
  `CHK_ASSERT(a_acc, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "back-to-back accept")
  `CHK_ASSERT(a_kov, clk, rst_n, out_valid |-> !(out_data.kept && out_data.overflow), "kept and overflow")
  `CHK_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result dropped")
  `CHK_ASSERT_ALWAYS(a_prdy, clk, cfg_pready, "pready low")
endmodule
bind lidar_projection_occlusion_filter lpof_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data, .cfg_pready
);
`default_nettype wire
